// ===== sv/lru_key_value_cache_macros.svh =====
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shared checking shorthands, clocked on aclk and quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// property that must hold at every edge out of reset
`define LKVC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// consequence checked in the cycle after the trigger
`define LKVC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key/value cache cell row and top.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // one slot of the recency ordered row
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // strobes broadcast to every cell
    typedef struct packed {
        logic probe;   // compare stored key against incoming request
        logic upd;     // apply the update for the pending request
        logic ins;     // insert: whole row shifts toward the tail
    } ctrl_t;

endpackage

// ===== sv/lkvc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell
// One slot of the recency row: key compare, hit chain and shift from the
// neighbor closer to the head.
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lkvc_pkg::ctrl_t                     ctrl,
    input  logic                                evict,
    input  logic [lkvc_pkg::KEY_W-1:0]          probe_key,
    input  lkvc_pkg::entry_t                    prev_entry,
    output lkvc_pkg::entry_t                    entry,
    input  logic                                hit_ge_in,
    output logic                                hit_ge_out,
    input  logic [lkvc_pkg::VAL_W-1:0]          hit_val_in,
    output logic [lkvc_pkg::VAL_W-1:0]          hit_val_out
);
    import lkvc_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             match_reg;
    logic             shift;

    // hit at this slot or further toward the tail
    assign hit_ge_out  = match_reg | hit_ge_in;
    assign hit_val_out = (match_reg ? value_reg : '0) | hit_val_in;
    assign shift       = ctrl.upd & (ctrl.ins | hit_ge_out);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.probe) begin
                match_reg <= valid_reg && (key_reg == probe_key);
            end
            if (shift) begin
                valid_reg <= prev_entry.valid;
            end
            if (ctrl.upd && evict) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

endmodule

// ===== sv/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store kept in recency order by a row of cells.
// ----------------------------------------------------------------------------
// For each request, in the accept cycle every cell compares its key with the
// incoming one; once the update may go ahead, the row shifts one place
// toward the tail up to the hit slot (or across the whole row on an insert)
// and the result is registered. The OR chain carries the hit flag and value
// through all ENTRIES cells. A new request is taken the cycle after the
// update; the update waits while an earlier result is still held on the
// output. Slot 0 is always most recent, valid slots form a prefix of the
// row, and reset clears the valid bits at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: capacity
    input  logic                              cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic                              s_tuser,   // [0] op
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] read_value
    output logic                              m_tuser    // [0] found
);
    import lkvc_pkg::*;

    `include "lru_key_value_cache_macros.svh"

    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t           state_reg;
    logic             m_valid_reg;
    logic             m_found_reg;
    logic [VAL_W-1:0] m_data_reg;

    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg;
    op_t              req_op_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0] req_val_reg;

    logic             s_accept;
    logic             upd;
    logic             hit;
    logic             ins;
    logic             full;
    logic [CW-1:0]    count_grow;
    logic [CW-1:0]    count_next;
    logic [CMP_W-1:0] cap_x;
    logic [CMP_W-1:0] eff_cap;
    logic             evict_en;
    ctrl_t            ctrl;

    entry_t              chain [0:ENTRIES];
    logic [ENTRIES:0]    hit_ge;
    logic [VAL_W-1:0]    hit_val [0:ENTRIES];
    logic [ENTRIES-1:0]  evict_vec;
    logic [ENTRIES-1:0]  valid_vec;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign upd      = (state_reg == ST_UPDATE) && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    assign hit        = hit_ge[0];
    assign ins        = (req_op_reg == OP_PUT) && !hit;
    assign full       = (count_reg == CW'(ENTRIES));
    assign count_grow = count_reg + CW'(ins && !full);

    always_comb begin
        cap_x = CMP_W'(cap_reg);
        if (cap_x == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_x > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    // an insert into a full row drops its tail and evicts nothing further
    assign evict_en   = (req_op_reg == OP_PUT) && !(ins && full)
                        && (CMP_W'(count_grow) > eff_cap);
    assign count_next = evict_en ? count_grow - CW'(1) : count_grow;

    assign ctrl.probe = s_accept;
    assign ctrl.upd   = upd;
    assign ctrl.ins   = ins;

    // head of the row: the entry that becomes most recent
    assign chain[0].valid = 1'b1;
    assign chain[0].key   = req_key_reg;
    assign chain[0].value = (req_op_reg == OP_PUT) ? req_val_reg : hit_val[0];

    assign hit_ge[ENTRIES]  = 1'b0;
    assign hit_val[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        assign evict_vec[i] = evict_en && (count_grow - CW'(1) == CW'(i));
        assign valid_vec[i] = chain[i+1].valid;

        lkvc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .evict       (evict_vec[i]),
            .probe_key   (s_tdata[KEY_W-1:0]),
            .prev_entry  (chain[i]),
            .entry       (chain[i+1]),
            .hit_ge_in   (hit_ge[i+1]),
            .hit_ge_out  (hit_ge[i]),
            .hit_val_in  (hit_val[i+1]),
            .hit_val_out (hit_val[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (s_accept) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (upd) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b1;
                        m_found_reg <= hit;
                        m_data_reg  <= (req_op_reg == OP_GET && hit) ? hit_val[0]
                                                                     : MISS_VALUE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (upd) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_op_reg  <= op_t'(s_tuser);
            req_key_reg <= s_tdata[KEY_W-1:0];
            req_val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    `LKVC_ASSERT(a_count_matches_valid, $countones(valid_vec) == 32'(count_reg), "valid slots disagree with count")
    `LKVC_ASSERT(a_count_bound, count_reg <= CW'(ENTRIES), "entry count above row length")
    `LKVC_ASSERT_NEXT(a_one_request_in_flight, s_accept, !s_tready, "request taken during update")
    `LKVC_ASSERT_NEXT(a_result_after_update, upd, m_tvalid, "update left no result")

endmodule

// ===== tb/lru_key_value_cache_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test
// Self-checking bench for the LRU key/value cache. A queued plan of get/put
// requests, capacity writes and idle-pattern changes feeds a clocked driver.
// A recency-ordered cache model predicts found/read_value per request, and a
// clocked monitor compares each result in order, under varied back-pressure.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
    import lkvc_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int IDLE_GAP  = 4;      // cycles of quiet before a capacity write
    localparam int HOLD_LEN  = 200;    // long receiver hold-off
    localparam int POOL_SIZE = 24;

    typedef enum {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN,
        STEP_PHASE,
        STEP_HOLD
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [CAP_W-1:0]  cap;
        int                send_pct;
        int                recv_pct;
    } step_t;

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] value;
    } lookup_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tuser;

    // cache model state
    logic [KEY_W-1:0] kv_keys [ENTRIES];
    logic [VAL_W-1:0] kv_vals [ENTRIES];
    bit               kv_valid[ENTRIES];
    int               kv_rank [ENTRIES];
    int               kv_count = 0;
    logic [CAP_W-1:0] kv_capacity = CAP_RESET;

    step_t            plan[$];
    lookup_result_t   results_due[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;
    logic hold_trigger = 1'b0;
    int   hold_left = 0;
    int   errors = 0;

    lru_key_value_cache #(.ENTRIES(ENTRIES)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [31:0] lookup_key, [63:32] write_value
        .s_tuser   (s_tuser),    // [0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [31:0] read_value
        .m_tuser   (m_tuser)     // [0] found
    );

    always #1 aclk = ~aclk;

    // ---------------- cache model ----------------
    function automatic void promote(int slot);
        int r;
        r = kv_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (kv_valid[i] && kv_rank[i] < r) kv_rank[i]++;
        kv_rank[slot] = 0;
    endfunction

    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (kv_valid[i] && (best < 0 || kv_rank[i] > kv_rank[best])) best = i;
        return best;
    endfunction

    function automatic lookup_result_t cache_access(input op_t op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] value);
        lookup_result_t res;
        int hit;
        int slot;
        int limit;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && kv_valid[i] && kv_keys[i] == key) hit = i;
        res.found = (hit >= 0);
        res.value = MISS_VALUE;
        if (op == OP_GET) begin
            if (hit >= 0) begin
                promote(hit);
                res.value = kv_vals[hit];
            end
            return res;
        end
        if (hit >= 0) begin
            kv_vals[hit] = value;
            promote(hit);
        end else begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !kv_valid[i]) slot = i;
            if (slot < 0) begin
                // row full: reuse the least recent slot, no further eviction
                slot = oldest_slot();
                promote(slot);
                kv_keys[slot] = key;
                kv_vals[slot] = value;
                return res;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (kv_valid[i]) kv_rank[i]++;
            kv_valid[slot] = 1'b1;
            kv_rank[slot] = 0;
            kv_keys[slot] = key;
            kv_vals[slot] = value;
            kv_count++;
        end
        limit = (kv_capacity == 0) ? 1 : ((kv_capacity > ENTRIES) ? ENTRIES : kv_capacity);
        if (kv_count > limit) begin
            slot = oldest_slot();
            if (slot >= 0) begin
                kv_valid[slot] = 1'b0;
                kv_rank[slot] = 0;
                kv_count--;
            end
        end
        return res;
    endfunction

    // ---------------- plan building ----------------
    function automatic void add_req(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        step_t s;
        s = '{kind: STEP_REQ, op: op, key: key, value: value, cap: '0,
              send_pct: 0, recv_pct: 0};
        plan.push_back(s);
    endfunction

    function automatic void add_step(step_kind_t kind, logic [CAP_W-1:0] cap,
                                     int send_pct, int recv_pct);
        step_t s;
        s = '{kind: kind, op: OP_GET, key: '0, value: '0, cap: cap,
              send_pct: send_pct, recv_pct: recv_pct};
        plan.push_back(s);
    endfunction

    // ---------------- request driver ----------------
    always @(posedge aclk) begin
        logic  offer;
        logic  we;
        logic  hold;
        step_t head;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_we <= 1'b0;
            hold_trigger <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            we = 1'b0;
            hold = 1'b0;
            offer = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
                results_due.push_back(cache_access(op_t'(s_tuser), s_tdata[31:0],
                                                   s_tdata[63:32]));
            if (s_tvalid || results_due.size() != 0)
                quiet_cycles <= 0;
            else if (quiet_cycles < 1000)
                quiet_cycles <= quiet_cycles + 1;
            if (!offer && plan.size() != 0) begin
                head = plan[0];
                case (head.kind)
                    STEP_PHASE: begin
                        send_idle_pct <= head.send_pct;
                        recv_stall_pct <= head.recv_pct;
                        void'(plan.pop_front());
                    end
                    STEP_HOLD: begin
                        hold = 1'b1;
                        void'(plan.pop_front());
                    end
                    STEP_DRAIN: begin
                        if (quiet_cycles >= IDLE_GAP && !s_tvalid) void'(plan.pop_front());
                    end
                    STEP_CFG: begin
                        if (quiet_cycles >= IDLE_GAP && !s_tvalid) begin
                            we = 1'b1;
                            cfg_wdata <= head.cap;
                            kv_capacity = head.cap;
                            void'(plan.pop_front());
                        end
                    end
                    default: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            offer = 1'b1;
                            s_tdata <= {head.value, head.key};
                            s_tuser <= head.op;
                            void'(plan.pop_front());
                        end
                    end
                endcase
            end
            s_tvalid <= offer;
            cfg_we <= we;
            hold_trigger <= hold;
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: found %0b read_value %h", m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("read_value: expected %h, actual %h", want.value, m_tdata);
                        errors++;
                    end
                end
            end
            if (hold_trigger) begin
                hold_left <= HOLD_LEN;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        logic [CAP_W-1:0] caps[8];
        int               mode_send[4];
        int               mode_recv[4];
        logic [KEY_W-1:0] key;
        int               n;

        mode_send = '{0, 70, 0, 23};
        mode_recv = '{0, 0, 70, 23};
        caps = '{5'd16, 5'd31, 5'd1, 5'd0, CAP_W'($urandom_range(2, 15)),
                 5'd8, 5'd31, 5'd16};
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

        // directed: empty lookup, extreme keys and values, update, lowered capacity
        add_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
        add_req(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
        add_req(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
        add_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        add_req(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
        add_req(OP_GET, 32'h8000_0000, 32'hffff_ffff);
        add_req(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
        add_req(OP_GET, 32'h0000_0000, 32'h5555_5555);
        add_req(OP_GET, 32'hffff_ffff, 32'haaaa_aaaa);
        add_req(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        add_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
        add_req(OP_GET, 32'h0000_0001, 32'h0000_0000);
        add_step(STEP_CFG, 5'd1, 0, 0);     // below current count, nothing evicted yet
        add_req(OP_PUT, 32'h0000_0005, 32'h0000_000a);
        add_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
        add_req(OP_PUT, 32'hffff_ffff, 32'h0000_0001);   // update while over capacity
        add_req(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
        add_step(STEP_CFG, 5'd0, 0, 0);
        add_req(OP_PUT, 32'h0000_0006, 32'hdead_beef);
        add_req(OP_GET, 32'h0000_0005, 32'h0000_0000);
        add_step(STEP_CFG, 5'd31, 0, 0);
        add_req(OP_PUT, 32'h7fff_fffe, 32'h0000_0000);
        add_req(OP_GET, 32'h0000_0006, 32'h0000_0000);

        // random phases, pool keys give hits and keep the row full
        for (int p = 0; p < 8; p++) begin
            add_step(STEP_CFG, caps[p], 0, 0);
            add_step(STEP_PHASE, '0, mode_send[p % 4], mode_recv[p % 4]);
            if (p == 0) add_step(STEP_HOLD, '0, 0, 0);
            for (int i = 0; i < 116; i++) begin
                if (p == 4 && i == 58) add_step(STEP_DRAIN, '0, 0, 0);
                key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                : $urandom();
                add_req(op_t'($urandom_range(1)), key, $urandom());
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (plan.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge aclk);
        n = 0;
        while (n < 20) begin
            @(posedge aclk);
            n++;
        end
        if (errors == 0 && results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lkvc_pkg.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache.sv
tb/lru_key_value_cache_test.sv
